/* hw/rtl/lbvh_pkg.sv */
`default_nettype none
// ============================================================================
// LBVH build package
// Widths, item kinds, request types and the leading-zero count shared by the
// radix tree build unit and its prefix-measure datapath.
// ============================================================================
package lbvh_pkg;

   localparam int MAX_PRIMS = 1024;
   localparam int IDX_W     = $clog2(MAX_PRIMS);
   localparam int NODE_W    = IDX_W + 1;
   localparam int POS_W     = IDX_W + 3;
   localparam int CODE_W    = 32;
   localparam int KIND_W    = 2;
   localparam int LZ_W      = 6;
   localparam int DELTA_W   = 8;

   localparam logic [KIND_W-1:0] KIND_LOAD     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_INTERNAL = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LEAF     = 2'd2;

   // Prefix measure outside the key range, and of a key against itself.
   localparam logic signed [DELTA_W-1:0] DELTA_NONE = -8'sd1;
   localparam logic signed [DELTA_W-1:0] DELTA_SELF = DELTA_W'(2 * CODE_W);

   typedef struct packed {
      logic                    issue;
      logic signed [POS_W-1:0] a_pos;
      logic signed [POS_W-1:0] b_pos;
   } delta_req_type;

   typedef struct packed {
      logic              wr_en;
      logic [IDX_W-1:0]  addr;
      logic [CODE_W-1:0] code;
   } load_type;

   // Leading zeros of a 32-bit word as a five-level halving search.
   function automatic logic [LZ_W-1:0] lead_zeros(input logic [CODE_W-1:0] v);
      logic [CODE_W-1:0] x;
      logic [LZ_W-1:0]   n;
      x = v;
      n = '0;
      if (x[31:16] == 16'h0000) begin
         n[4] = 1'b1;
         x    = {x[15:0], 16'h0000};
      end
      if (x[31:24] == 8'h00) begin
         n[3] = 1'b1;
         x    = {x[23:0], 8'h00};
      end
      if (x[31:28] == 4'h0) begin
         n[2] = 1'b1;
         x    = {x[27:0], 4'h0};
      end
      if (x[31:30] == 2'b00) begin
         n[1] = 1'b1;
         x    = {x[29:0], 2'b00};
      end
      if (x[31] == 1'b0) begin
         n[0] = 1'b1;
      end
      if (v == '0) begin
         n = LZ_W'(CODE_W);
      end
      return n;
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/lbvh_ram.sv */
`default_nettype none
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port; the read data is registered.
// ============================================================================
module lbvh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* hw/rtl/lbvh_delta.sv */
`default_nettype none
// ============================================================================
// LBVH prefix-measure unit
// Holds two copies of the code store so that both keys of a pair are read
// together, and forms the prefix measure the cycle after a request.
// ============================================================================
module lbvh_delta (
   input  logic                                 clock,
   input  lbvh_pkg::load_type                   load,
   input  lbvh_pkg::delta_req_type              dreq,
   input  logic [lbvh_pkg::NODE_W-1:0]          count,
   output logic signed [lbvh_pkg::DELTA_W-1:0]  prefix_len
);
   import lbvh_pkg::*;

   logic signed [POS_W-1:0] lo_pos;
   logic signed [POS_W-1:0] hi_pos;
   logic signed [POS_W-1:0] count_pos;
   logic [IDX_W-1:0]        lo_in, lo_ff;
   logic [IDX_W-1:0]        hi_in, hi_ff;
   logic                    in_range_in, in_range_ff;
   logic [CODE_W-1:0]       code_a;
   logic [CODE_W-1:0]       code_b;
   logic [CODE_W-1:0]       code_x;
   logic [CODE_W-1:0]       idx_x;

   always_comb begin
      count_pos   = POS_W'(count);
      lo_pos      = (dreq.a_pos < dreq.b_pos) ? dreq.a_pos : dreq.b_pos;
      hi_pos      = (dreq.a_pos < dreq.b_pos) ? dreq.b_pos : dreq.a_pos;
      lo_in       = lo_pos[IDX_W-1:0];
      hi_in       = hi_pos[IDX_W-1:0];
      in_range_in = (lo_pos >= 0) && (hi_pos < count_pos);
   end

   always_ff @(posedge clock) begin
      if (dreq.issue) begin
         lo_ff       <= lo_in;
         hi_ff       <= hi_in;
         in_range_ff <= in_range_in;
      end
   end

   lbvh_ram #(.WIDTH(CODE_W), .DEPTH(MAX_PRIMS)) u_code_a (
      .clock   (clock),
      .wr_en   (load.wr_en),
      .wr_addr (load.addr),
      .wr_data (load.code),
      .rd_en   (dreq.issue),
      .rd_addr (lo_in),
      .rd_data (code_a)
   );

   lbvh_ram #(.WIDTH(CODE_W), .DEPTH(MAX_PRIMS)) u_code_b (
      .clock   (clock),
      .wr_en   (load.wr_en),
      .wr_addr (load.addr),
      .wr_data (load.code),
      .rd_en   (dreq.issue),
      .rd_addr (hi_in),
      .rd_data (code_b)
   );

   // Equal codes fall back to the slot numbers, which always differ in a
   // sorted list except when a key is compared with itself.
   always_comb begin
      code_x = code_a ^ code_b;
      idx_x  = CODE_W'(lo_ff ^ hi_ff);
      if (!in_range_ff) begin
         prefix_len = DELTA_NONE;
      end else if (code_x != '0) begin
         prefix_len = DELTA_W'(lead_zeros(code_x));
      end else begin
         prefix_len = DELTA_W'(CODE_W) + DELTA_W'(lead_zeros(idx_x));
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/lbvh_hierarchy_build_unit.sv */
`default_nettype none
// ============================================================================
// LBVH hierarchy build unit
// Radix tree node construction over a store of sorted Morton codes.
// ============================================================================
// Usage. The csr_ channel writes the primitive count (always ready). On the
// req_ channel a load item stores one sorted code and its primitive index in
// a slot and gives no result. An internal node query returns the node's two
// children on the rsp_ channel, and a leaf query returns the stored primitive
// index as both children. Queries beyond the current count give no result.
// Every prefix measure evaluation reads both codes from the duplicated code
// store in an issue state and forms the measure and steps the search in the
// evaluate state that follows. An internal query measures both neighbours,
// then runs doubling, bisection and split steps before its result shows. The
// unit handles one item at a time: req_ready is high only while it is idle,
// and it returns to idle once the result has moved into the output register.
// When the receiver stalls the result waits there, and a following query
// that finishes meanwhile waits in its last state. Reset sets the count to
// one, empties the output register and idles the sequencer; the stores are
// not cleared and a slot must be loaded before a query reads it.
// ============================================================================
module lbvh_hierarchy_build_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [lbvh_pkg::NODE_W-1:0]      csr_wdata,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [lbvh_pkg::KIND_W-1:0]      req_kind,
   input  logic [lbvh_pkg::IDX_W-1:0]       req_slot,
   input  logic [lbvh_pkg::CODE_W-1:0]      req_code,
   input  logic [lbvh_pkg::IDX_W-1:0]       req_prim_index,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [lbvh_pkg::NODE_W-1:0]      rsp_left_child,
   output logic [lbvh_pkg::NODE_W-1:0]      rsp_right_child
);
   import lbvh_pkg::*;

   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] S_IDLE    = 4'd0;
   localparam logic [ST_W-1:0] S_LEAF    = 4'd1;
   localparam logic [ST_W-1:0] S_NB_ISS  = 4'd2;
   localparam logic [ST_W-1:0] S_NB_EV   = 4'd3;
   localparam logic [ST_W-1:0] S_NA_ISS  = 4'd4;
   localparam logic [ST_W-1:0] S_NA_EV   = 4'd5;
   localparam logic [ST_W-1:0] S_DBL_ISS = 4'd6;
   localparam logic [ST_W-1:0] S_DBL_EV  = 4'd7;
   localparam logic [ST_W-1:0] S_BIN_ISS = 4'd8;
   localparam logic [ST_W-1:0] S_BIN_EV  = 4'd9;
   localparam logic [ST_W-1:0] S_NUM_ISS = 4'd10;
   localparam logic [ST_W-1:0] S_NUM_EV  = 4'd11;
   localparam logic [ST_W-1:0] S_SPL_ISS = 4'd12;
   localparam logic [ST_W-1:0] S_SPL_EV  = 4'd13;
   localparam logic [ST_W-1:0] S_DONE    = 4'd14;

   // Control state.
   logic [ST_W-1:0]   state_in, state_ff;
   logic [NODE_W-1:0] count_in, count_ff;
   logic              rsp_valid_in, rsp_valid_ff;

   // Search state and result payload.
   logic [IDX_W-1:0]          i_in, i_ff;
   logic                      dir_pos_in, dir_pos_ff;
   logic                      dir_neg_in, dir_neg_ff;
   logic signed [DELTA_W-1:0] dplus_in, dplus_ff;
   logic signed [DELTA_W-1:0] dmin_in, dmin_ff;
   logic signed [DELTA_W-1:0] numid_in, numid_ff;
   logic [NODE_W-1:0]         lmax_in, lmax_ff;
   logic [NODE_W-1:0]         t_in, t_ff;
   logic [NODE_W-1:0]         l_in, l_ff;
   logic [IDX_W-1:0]          first_in, first_ff;
   logic [IDX_W-1:0]          last_in, last_ff;
   logic [IDX_W-1:0]          lo_in, lo_ff;
   logic [IDX_W-1:0]          hi_in, hi_ff;
   logic [IDX_W-1:0]          mid_in, mid_ff;
   logic [NODE_W-1:0]         rsp_left_in, rsp_left_ff;
   logic [NODE_W-1:0]         rsp_right_in, rsp_right_ff;

   logic                      req_accept;
   logic [NODE_W-1:0]         eff_count;
   logic [NODE_W-1:0]         leaf_base;
   logic                      query_ok;
   logic                      leaf_ok;
   logic                      out_free;
   logic signed [POS_W-1:0]   i_pos;
   logic [NODE_W-1:0]         step_off;
   logic signed [POS_W-1:0]   off_pos;
   logic signed [POS_W-1:0]   step_pos;
   logic [IDX_W-1:0]          far_idx;
   logic [NODE_W-1:0]         mid_sum;
   logic [IDX_W-1:0]          mid_calc;
   logic [IDX_W-1:0]          spl_lo_next;
   logic [IDX_W-1:0]          spl_hi_next;
   logic [NODE_W-1:0]         split_next;
   logic [NODE_W-1:0]         left_node;
   logic [NODE_W-1:0]         right_node;
   logic [IDX_W-1:0]          prim_data;
   logic signed [DELTA_W-1:0] prefix_len;
   delta_req_type             dreq;
   load_type                  load;

   // ------------------------------------------------------------------------
   // Handshakes and the clamped primitive count.
   // ------------------------------------------------------------------------
   assign csr_ready  = 1'b1;
   assign req_ready  = (state_ff == S_IDLE);
   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_child  = rsp_left_ff;
   assign rsp_right_child = rsp_right_ff;

   // A count of zero acts as one, and anything above the store size acts as
   // the store size.
   always_comb begin
      if (count_ff == '0) begin
         eff_count = NODE_W'(1);
      end else if (count_ff > NODE_W'(MAX_PRIMS)) begin
         eff_count = NODE_W'(MAX_PRIMS);
      end else begin
         eff_count = count_ff;
      end
   end

   assign leaf_base = eff_count - NODE_W'(1);
   assign query_ok  = (NODE_W'(req_slot) + NODE_W'(1)) < eff_count;
   assign leaf_ok   = NODE_W'(req_slot) < eff_count;

   // ------------------------------------------------------------------------
   // Stores. Loads write the code copies and the primitive index store at
   // once; the primitive store is read on every accepted item so that a leaf
   // query finds its data the next cycle.
   // ------------------------------------------------------------------------
   always_comb begin
      load.wr_en = req_accept && (req_kind == KIND_LOAD);
      load.addr  = req_slot;
      load.code  = req_code;
   end

   lbvh_ram #(.WIDTH(IDX_W), .DEPTH(MAX_PRIMS)) u_prim_store (
      .clock   (clock),
      .wr_en   (load.wr_en),
      .wr_addr (req_slot),
      .wr_data (req_prim_index),
      .rd_en   (req_accept),
      .rd_addr (req_slot),
      .rd_data (prim_data)
   );

   lbvh_delta u_delta (
      .clock      (clock),
      .load       (load),
      .dreq       (dreq),
      .count      (eff_count),
      .prefix_len (prefix_len)
   );

   // ------------------------------------------------------------------------
   // Key positions. One adder steps from node i along the chosen direction by
   // the doubling bound, the bisection probe or the final span length.
   // ------------------------------------------------------------------------
   assign i_pos = POS_W'(i_ff);

   always_comb begin
      case (state_ff)
         S_DBL_ISS: begin
            step_off = lmax_ff;
         end
         S_BIN_ISS: begin
            step_off = l_ff + t_ff;
         end
         default: begin
            step_off = l_ff;
         end
      endcase
      off_pos = POS_W'(step_off);
      if (dir_pos_ff) begin
         step_pos = i_pos + off_pos;
      end else if (dir_neg_ff) begin
         step_pos = i_pos - off_pos;
      end else begin
         step_pos = i_pos;
      end
   end

   assign far_idx  = step_pos[IDX_W-1:0];
   assign mid_sum  = NODE_W'(lo_ff) + NODE_W'(hi_ff);
   assign mid_calc = mid_sum[IDX_W:1];

   // Requests to the prefix-measure unit, one in every issue state.
   always_comb begin
      dreq.issue = 1'b0;
      dreq.a_pos = i_pos;
      dreq.b_pos = i_pos;
      case (state_ff)
         S_NB_ISS: begin
            dreq.issue = 1'b1;
            dreq.b_pos = i_pos + POS_W'(1);
         end
         S_NA_ISS: begin
            dreq.issue = 1'b1;
            dreq.b_pos = i_pos - POS_W'(1);
         end
         S_DBL_ISS, S_BIN_ISS, S_NUM_ISS: begin
            dreq.issue = 1'b1;
            dreq.b_pos = step_pos;
         end
         S_SPL_ISS: begin
            dreq.issue = 1'b1;
            dreq.a_pos = POS_W'(lo_ff);
            dreq.b_pos = POS_W'(mid_calc);
         end
         default: begin
            dreq.issue = 1'b0;
         end
      endcase
   end

   // Split bisection step and the child numbering. A child covering a single
   // key is a leaf, numbered after all internal nodes.
   always_comb begin
      spl_lo_next = lo_ff;
      spl_hi_next = hi_ff;
      if (prefix_len > numid_ff) begin
         spl_lo_next = mid_ff;
      end else begin
         spl_hi_next = mid_ff;
      end
      split_next = NODE_W'(lo_ff) + NODE_W'(1);
      left_node  = (lo_ff == first_ff) ? leaf_base + NODE_W'(lo_ff) : NODE_W'(lo_ff);
      right_node = (split_next == NODE_W'(last_ff)) ? leaf_base + split_next : split_next;
   end

   // ------------------------------------------------------------------------
   // Sequencer. Each search step issues one pair of keys and evaluates the
   // measure in the following cycle.
   // ------------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      i_in         = i_ff;
      dir_pos_in   = dir_pos_ff;
      dir_neg_in   = dir_neg_ff;
      dplus_in     = dplus_ff;
      dmin_in      = dmin_ff;
      numid_in     = numid_ff;
      lmax_in      = lmax_ff;
      t_in         = t_ff;
      l_in         = l_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;

      if (csr_valid && csr_ready) begin
         count_in = csr_wdata;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if ((req_kind == KIND_INTERNAL) && query_ok) begin
                  i_in     = req_slot;
                  state_in = S_NB_ISS;
               end else if ((req_kind == KIND_LEAF) && leaf_ok) begin
                  state_in = S_LEAF;
               end
            end
         end
         S_LEAF: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_left_in  = NODE_W'(prim_data);
               rsp_right_in = NODE_W'(prim_data);
               state_in     = S_IDLE;
            end
         end
         S_NB_ISS: begin
            state_in = S_NB_EV;
         end
         S_NB_EV: begin
            dplus_in = prefix_len;
            state_in = S_NA_ISS;
         end
         S_NA_ISS: begin
            state_in = S_NA_EV;
         end
         S_NA_EV: begin
            // The span grows towards the neighbour sharing the longer prefix;
            // the measure on the other side bounds the search.
            dir_pos_in = dplus_ff > prefix_len;
            dir_neg_in = dplus_ff < prefix_len;
            if (dplus_ff > prefix_len) begin
               dmin_in = prefix_len;
            end else if (dplus_ff < prefix_len) begin
               dmin_in = dplus_ff;
            end else begin
               dmin_in = DELTA_SELF;
            end
            lmax_in  = NODE_W'(2);
            state_in = S_DBL_ISS;
         end
         S_DBL_ISS: begin
            state_in = S_DBL_EV;
         end
         S_DBL_EV: begin
            if (prefix_len > dmin_ff) begin
               lmax_in  = {lmax_ff[NODE_W-2:0], 1'b0};
               state_in = S_DBL_ISS;
            end else begin
               t_in     = {1'b0, lmax_ff[NODE_W-1:1]};
               l_in     = '0;
               state_in = S_BIN_ISS;
            end
         end
         S_BIN_ISS: begin
            state_in = S_BIN_EV;
         end
         S_BIN_EV: begin
            if (prefix_len > dmin_ff) begin
               l_in = l_ff + t_ff;
            end
            if (t_ff > NODE_W'(1)) begin
               t_in     = {1'b0, t_ff[NODE_W-1:1]};
               state_in = S_BIN_ISS;
            end else begin
               state_in = S_NUM_ISS;
            end
         end
         S_NUM_ISS: begin
            // The far end is fixed now; the span runs from first to last.
            if (step_pos < i_pos) begin
               first_in = far_idx;
               last_in  = i_ff;
               lo_in    = far_idx;
               hi_in    = i_ff;
            end else begin
               first_in = i_ff;
               last_in  = far_idx;
               lo_in    = i_ff;
               hi_in    = far_idx;
            end
            state_in = S_NUM_EV;
         end
         S_NUM_EV: begin
            numid_in = prefix_len;
            state_in = S_SPL_ISS;
         end
         S_SPL_ISS: begin
            mid_in   = mid_calc;
            state_in = S_SPL_EV;
         end
         S_SPL_EV: begin
            lo_in = spl_lo_next;
            hi_in = spl_hi_next;
            if (NODE_W'(spl_hi_next) > (NODE_W'(spl_lo_next) + NODE_W'(1))) begin
               state_in = S_SPL_ISS;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_left_in  = left_node;
               rsp_right_in = right_node;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= NODE_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff         <= i_in;
      dir_pos_ff   <= dir_pos_in;
      dir_neg_ff   <= dir_neg_in;
      dplus_ff     <= dplus_in;
      dmin_ff      <= dmin_in;
      numid_ff     <= numid_in;
      lmax_ff      <= lmax_in;
      t_ff         <= t_in;
      l_ff         <= l_in;
      first_ff     <= first_in;
      last_ff      <= last_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
   end

endmodule
`default_nettype wire
